@@ hdl/gbi_pkg.sv @@
// ----------------------------------------------------------------------------
// gbi_pkg
// shared beat types, function codes and arithmetic constants for the
// bilinear grid interpolator
// ----------------------------------------------------------------------------
package gbi_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned INDEX_W   = 12;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned WGT_W     = 17;
  localparam int unsigned ONE_Q16   = 65536;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DIV_STEPS = 17;

  localparam logic [1:0] FUNC_LOAD_X = 2'd0;
  localparam logic [1:0] FUNC_LOAD_Y = 2'd1;
  localparam logic [1:0] FUNC_LOAD_G = 2'd2;
  localparam logic [1:0] FUNC_QUERY  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_X_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_COUNT = 8'd1;

  typedef struct packed {
    logic [1:0]                func;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [VALUE_W-1:0] entry_value;
    logic signed [VALUE_W-1:0] point_x;
    logic signed [VALUE_W-1:0] point_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] interp_value;
    logic                      in_range;
  } out_beat_t;

endpackage

@@ hdl/gbi_ram.sv @@
// ----------------------------------------------------------------------------
// gbi_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module gbi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/grid_bilinear_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator_core
// bilinear interpolation over a non-uniform grid held in block memories
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o) carries load and query beats.
//   loads of x knots, y knots or grid values are written in the accept cycle
//   and give no result; one load is taken every cycle while the block is idle.
//   a query reads both end knots, runs an upper-bound binary search on each
//   axis over the knot memories (each step a read state and a compare
//   state), reads the cell corners, then runs four 17-step restoring
//   dividers for the weights while the four grid values are fetched, and
//   ends with two registered multiply stages. no new beat is taken until
//   the query has left its output state for idle; an outside point skips
//   the search and goes from the range check straight to the output state.
//   results leave through an output register (out_valid_o / out_stall_i);
//   loads are still taken while a result waits, a finished query waits in
//   its last state until the register is free.
//   configuration (cfg_valid_i / cfg_ready_o) is always ready; index 0 is
//   x_count and index 1 is y_count, other indices are dropped.
//   reset clears control state and sets both counts to 64; memory contents
//   are undefined until written.
// ----------------------------------------------------------------------------
module grid_bilinear_interpolator_core #(
  parameter int unsigned MAX_X_KNOTS = 64,
  parameter int unsigned MAX_Y_KNOTS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  gbi_pkg::in_beat_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output gbi_pkg::out_beat_t                   out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gbi_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [gbi_pkg::COUNT_W-1:0]          cfg_data_i
);

  import gbi_pkg::*;

  localparam int unsigned GRID_DEPTH = MAX_X_KNOTS * MAX_Y_KNOTS;
  localparam int unsigned XAW = $clog2(MAX_X_KNOTS);
  localparam int unsigned YAW = $clog2(MAX_Y_KNOTS);
  localparam int unsigned GAW = $clog2(GRID_DEPTH);
  localparam int unsigned XCW = $clog2(MAX_X_KNOTS + 1);
  localparam int unsigned YCW = $clog2(MAX_Y_KNOTS + 1);
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);
  localparam int unsigned NUM_W = VALUE_W + 1;
  localparam int unsigned REM_W = VALUE_W + 2;
  localparam int unsigned P1_W = WGT_W + 1 + VALUE_W;
  localparam int unsigned R_W = P1_W + 1 - FRAC_W;
  localparam int unsigned P2_W = WGT_W + 1 + R_W;
  localparam int unsigned S_W = P2_W + 1 - FRAC_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RNG0, ST_RNG1, ST_RNG2, ST_SRCH_RD, ST_SRCH_CMP,
    ST_CELL0, ST_CELL1, ST_CELL2, ST_DIV, ST_MUL1, ST_SUM1, ST_MUL2, ST_OUT
  } state_e;

  state_e    state_q;
  logic      out_valid_q;
  out_beat_t out_q;
  logic [COUNT_W-1:0] x_count_q, y_count_q;

  // query datapath
  logic signed [VALUE_W-1:0] px_q, py_q, x_first_q, y_first_q;
  logic signed [VALUE_W-1:0] xa_q, ya_q;
  logic [XCW-1:0] xlo_q, xhi_q;
  logic [YCW-1:0] ylo_q, yhi_q;
  logic [XAW-1:0] xi_q;
  logic [YAW-1:0] yj_q;
  logic [GAW-1:0] base_q;
  logic [STEP_W-1:0] step_q;
  logic           in_rng_q;
  logic [REM_W-1:0] rem_q [4];
  logic [NUM_W-1:0] den_q [4];
  logic [WGT_W-1:0] quo_q [4];
  logic [WGT_W-1:0] fix_val_q [4];
  logic             fix_q [4];
  logic signed [VALUE_W-1:0] g_q [4];
  logic signed [P1_W-1:0] p1_q [4];
  logic signed [R_W-1:0]  r_q [2];
  logic signed [P2_W-1:0] p2_q [2];

  logic in_acc;
  logic [XCW-1:0] nx;
  logic [YCW-1:0] ny;
  logic [XCW-1:0] xmid;
  logic [YCW-1:0] ymid;
  logic           xdone, ydone;
  logic [XAW-1:0] xi_c;
  logic [YAW-1:0] yj_c;
  logic [XAW-1:0] x_raddr;
  logic [YAW-1:0] y_raddr;
  logic [GAW-1:0] g_raddr;
  logic signed [VALUE_W-1:0] x_rdata, y_rdata, g_rdata;
  logic x_we, y_we, g_we;
  logic [WGT_W-1:0] w [4];
  logic signed [P1_W:0] sum1 [2];
  logic signed [P2_W:0] sum2;
  logic signed [S_W-1:0] shifted;
  logic signed [VALUE_W-1:0] sat_val;
  logic out_free;
  logic out_range;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // effective knot counts
  always_comb begin
    if (x_count_q < COUNT_W'(2)) begin
      nx = XCW'(2);
    end else if (32'(x_count_q) > MAX_X_KNOTS) begin
      nx = XCW'(MAX_X_KNOTS);
    end else begin
      nx = XCW'(x_count_q);
    end
    if (y_count_q < COUNT_W'(2)) begin
      ny = YCW'(2);
    end else if (32'(y_count_q) > MAX_Y_KNOTS) begin
      ny = YCW'(MAX_Y_KNOTS);
    end else begin
      ny = YCW'(y_count_q);
    end
  end

  assign xmid  = XCW'((32'(xlo_q) + 32'(xhi_q)) >> 1);
  assign ymid  = YCW'((32'(ylo_q) + 32'(yhi_q)) >> 1);
  assign xdone = (xlo_q >= xhi_q);
  assign ydone = (ylo_q >= yhi_q);

  // cell index from upper bound, clamped to the first and last cell
  always_comb begin
    if (xlo_q == '0) begin
      xi_c = '0;
    end else if (xlo_q - XCW'(1) > nx - XCW'(2)) begin
      xi_c = XAW'(nx - XCW'(2));
    end else begin
      xi_c = XAW'(xlo_q - XCW'(1));
    end
    if (ylo_q == '0) begin
      yj_c = '0;
    end else if (ylo_q - YCW'(1) > ny - YCW'(2)) begin
      yj_c = YAW'(ny - YCW'(2));
    end else begin
      yj_c = YAW'(ylo_q - YCW'(1));
    end
  end

  // memory read addresses
  always_comb begin
    x_raddr = '0;
    y_raddr = '0;
    g_raddr = base_q;
    case (state_q)
      ST_RNG1: begin
        x_raddr = XAW'(nx - XCW'(1));
        y_raddr = YAW'(ny - YCW'(1));
      end
      ST_SRCH_RD: begin
        x_raddr = XAW'(xmid);
        y_raddr = YAW'(ymid);
      end
      ST_CELL0: begin
        x_raddr = xi_c;
        y_raddr = yj_c;
      end
      ST_CELL1: begin
        x_raddr = xi_q + XAW'(1);
        y_raddr = yj_q + YAW'(1);
      end
      ST_DIV: begin
        case (step_q)
          STEP_W'(0): g_raddr = base_q;
          STEP_W'(1): g_raddr = GAW'(32'(base_q) + 32'd1);
          STEP_W'(2): g_raddr = GAW'(32'(base_q) + 32'(ny));
          default:    g_raddr = GAW'(32'(base_q) + 32'(ny) + 32'd1);
        endcase
      end
      default: begin
        x_raddr = '0;
      end
    endcase
  end

  assign x_we = in_acc && (in_data_i.func == FUNC_LOAD_X)
             && (32'(in_data_i.entry_index) < MAX_X_KNOTS);
  assign y_we = in_acc && (in_data_i.func == FUNC_LOAD_Y)
             && (32'(in_data_i.entry_index) < MAX_Y_KNOTS);
  assign g_we = in_acc && (in_data_i.func == FUNC_LOAD_G)
             && (32'(in_data_i.entry_index) < GRID_DEPTH);

  gbi_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_X_KNOTS)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (XAW'(in_data_i.entry_index)),
    .wdata_i (in_data_i.entry_value),
    .raddr_i (x_raddr),
    .rdata_o (x_rdata)
  );

  gbi_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_Y_KNOTS)) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (y_we),
    .waddr_i (YAW'(in_data_i.entry_index)),
    .wdata_i (in_data_i.entry_value),
    .raddr_i (y_raddr),
    .rdata_o (y_rdata)
  );

  gbi_ram #(.WIDTH(VALUE_W), .DEPTH(GRID_DEPTH)) u_g_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (GAW'(in_data_i.entry_index)),
    .wdata_i (in_data_i.entry_value),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  // final weights and blend arithmetic
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (fix_q[k]) begin
        w[k] = fix_val_q[k];
      end else if (32'(quo_q[k]) > ONE_Q16) begin
        w[k] = WGT_W'(ONE_Q16);
      end else begin
        w[k] = quo_q[k];
      end
    end
    sum1[0] = (P1_W+1)'(p1_q[0]) + (P1_W+1)'(p1_q[1]);
    sum1[1] = (P1_W+1)'(p1_q[2]) + (P1_W+1)'(p1_q[3]);
    sum2    = (P2_W+1)'(p2_q[0]) + (P2_W+1)'(p2_q[1]);
    shifted = S_W'(sum2 >>> FRAC_W);
    if (shifted > S_W'($signed({1'b0, {(VALUE_W-1){1'b1}}}))) begin
      sat_val = {1'b0, {(VALUE_W-1){1'b1}}};
    end else if (shifted < S_W'($signed({1'b1, {(VALUE_W-1){1'b0}}}))) begin
      sat_val = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      sat_val = VALUE_W'(shifted);
    end
  end

  assign out_range = (px_q >= x_first_q) && (px_q <= x_rdata)
                  && (py_q >= y_first_q) && (py_q <= y_rdata);

  // control, count and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      x_count_q   <= COUNT_W'(64);
      y_count_q   <= COUNT_W'(64);
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_X_COUNT: x_count_q <= cfg_data_i;
          REG_Y_COUNT: y_count_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && in_data_i.func == FUNC_QUERY) begin
            state_q <= ST_RNG0;
          end
        end
        ST_RNG0: state_q <= ST_RNG1;
        ST_RNG1: state_q <= ST_RNG2;
        ST_RNG2: state_q <= out_range ? ST_SRCH_RD : ST_OUT;
        ST_SRCH_RD: state_q <= (xdone && ydone) ? ST_CELL0 : ST_SRCH_CMP;
        ST_SRCH_CMP: state_q <= ST_SRCH_RD;
        ST_CELL0: state_q <= ST_CELL1;
        ST_CELL1: state_q <= ST_CELL2;
        ST_CELL2: state_q <= ST_DIV;
        ST_DIV: begin
          if (step_q == STEP_W'(DIV_STEPS - 1)) begin
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1: state_q <= ST_SUM1;
        ST_SUM1: state_q <= ST_MUL2;
        ST_MUL2: state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            out_valid_q        <= 1'b1;
            out_q.in_range     <= in_rng_q;
            out_q.interp_value <= in_rng_q ? sat_val : '0;
            state_q            <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // query datapath registers
  always_ff @(posedge clk_i) begin
    logic signed [NUM_W-1:0] a33, b33, c33, d33, num33;
    logic [REM_W-1:0] r_sh;
    case (state_q)
      ST_IDLE: begin
        px_q <= in_data_i.point_x;
        py_q <= in_data_i.point_y;
      end
      ST_RNG1: begin
        x_first_q <= x_rdata;
        y_first_q <= y_rdata;
      end
      ST_RNG2: begin
        in_rng_q <= out_range;
        xlo_q    <= '0;
        xhi_q    <= nx;
        ylo_q    <= '0;
        yhi_q    <= ny;
      end
      ST_SRCH_CMP: begin
        if (!xdone) begin
          if (x_rdata <= px_q) begin
            xlo_q <= xmid + XCW'(1);
          end else begin
            xhi_q <= xmid;
          end
        end
        if (!ydone) begin
          if (y_rdata <= py_q) begin
            ylo_q <= ymid + YCW'(1);
          end else begin
            yhi_q <= ymid;
          end
        end
      end
      ST_CELL0: begin
        xi_q <= xi_c;
        yj_q <= yj_c;
      end
      ST_CELL1: begin
        xa_q   <= x_rdata;
        ya_q   <= y_rdata;
        base_q <= GAW'(32'(xi_q) * 32'(ny) + 32'(yj_q));
      end
      ST_CELL2: begin
        step_q <= '0;
        for (int k = 0; k < 4; k++) begin
          a33 = (k < 2) ? NUM_W'(xa_q) : NUM_W'(ya_q);
          b33 = (k < 2) ? NUM_W'(x_rdata) : NUM_W'(y_rdata);
          c33 = (k < 2) ? NUM_W'(px_q) : NUM_W'(py_q);
          d33 = b33 - a33;
          num33 = (k % 2 == 0) ? (b33 - c33) : (c33 - a33);
          rem_q[k] <= REM_W'(num33);
          den_q[k] <= d33;
          quo_q[k] <= '0;
          if (d33 <= 0) begin
            fix_q[k]     <= 1'b1;
            fix_val_q[k] <= (k % 2 == 0) ? WGT_W'(ONE_Q16) : '0;
          end else if (num33 <= 0) begin
            fix_q[k]     <= 1'b1;
            fix_val_q[k] <= '0;
          end else if ({1'b0, num33} >= {d33, 1'b0}) begin
            fix_q[k]     <= 1'b1;
            fix_val_q[k] <= WGT_W'(ONE_Q16);
          end else begin
            fix_q[k]     <= 1'b0;
            fix_val_q[k] <= '0;
          end
        end
      end
      ST_DIV: begin
        step_q <= step_q + STEP_W'(1);
        if (step_q >= STEP_W'(1) && step_q <= STEP_W'(4)) begin
          g_q[2'(step_q - STEP_W'(1))] <= g_rdata;
        end
        for (int k = 0; k < 4; k++) begin
          r_sh = (step_q == '0) ? rem_q[k] : {rem_q[k][REM_W-2:0], 1'b0};
          if (r_sh >= REM_W'(den_q[k])) begin
            rem_q[k] <= r_sh - REM_W'(den_q[k]);
            quo_q[k] <= {quo_q[k][WGT_W-2:0], 1'b1};
          end else begin
            rem_q[k] <= r_sh;
            quo_q[k] <= {quo_q[k][WGT_W-2:0], 1'b0};
          end
        end
      end
      ST_MUL1: begin
        p1_q[0] <= $signed({1'b0, w[0]}) * g_q[0];
        p1_q[1] <= $signed({1'b0, w[1]}) * g_q[2];
        p1_q[2] <= $signed({1'b0, w[0]}) * g_q[1];
        p1_q[3] <= $signed({1'b0, w[1]}) * g_q[3];
      end
      ST_SUM1: begin
        r_q[0] <= R_W'(sum1[0] >>> FRAC_W);
        r_q[1] <= R_W'(sum1[1] >>> FRAC_W);
      end
      ST_MUL2: begin
        p2_q[0] <= $signed({1'b0, w[2]}) * r_q[0];
        p2_q[1] <= $signed({1'b0, w[3]}) * r_q[1];
      end
      default: ;
    endcase
  end

  a_result_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result beat raised outside the output state");

  a_outside_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) && !out_q.in_range |-> out_q.interp_value == '0)
    else $error("outside point gave a non-zero value");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SRCH_CMP |-> xlo_q <= xhi_q && ylo_q <= yhi_q
                            && xhi_q <= nx && yhi_q <= ny)
    else $error("binary search bounds crossed");

  a_weights_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL1 |-> 32'(w[0]) <= ONE_Q16 && 32'(w[1]) <= ONE_Q16
                        && 32'(w[2]) <= ONE_Q16 && 32'(w[3]) <= ONE_Q16)
    else $error("weight above one");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL1 |-> $past(state_q == ST_DIV)
                        && $past(step_q) == STEP_W'(DIV_STEPS - 1))
    else $error("divider left early");

endmodule

@@ tb/gbi_checker.sv @@
// ----------------------------------------------------------------------------
// gbi_checker
// watches the load/query, result and register channels of the bilinear grid
// interpolator, keeps its own copy of knots, grid and counts, works out the
// value of every accepted query and compares each result beat in order
// ----------------------------------------------------------------------------
module gbi_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  gbi_pkg::in_beat_t             in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  gbi_pkg::out_beat_t            out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [gbi_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gbi_pkg::COUNT_W-1:0]   cfg_data_i,
  output int                            errors_o,
  output int                            pending_o
);

  import gbi_pkg::*;

  localparam int unsigned NX_MAX = 64;
  localparam int unsigned NY_MAX = 64;
  localparam int unsigned GRID_N = NX_MAX * NY_MAX;

  logic signed [VALUE_W-1:0] x_knot_mem [NX_MAX];
  logic signed [VALUE_W-1:0] y_knot_mem [NY_MAX];
  logic signed [VALUE_W-1:0] grid_mem   [GRID_N];
  logic [COUNT_W-1:0]        x_count_q;
  logic [COUNT_W-1:0]        y_count_q;
  out_beat_t                 result_q [$];
  int                        err_cnt;

  assign errors_o  = err_cnt;
  assign pending_o = result_q.size();

  function automatic int unsigned eff_count(logic [COUNT_W-1:0] c, int unsigned depth);
    if (c < 2) return 2;
    if (c > depth) return depth;
    return c;
  endfunction

  function automatic int unsigned cell_index(bit on_y, int unsigned n, longint c);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    longint      k;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      k = on_y ? longint'(y_knot_mem[mid]) : longint'(x_knot_mem[mid]);
      if (k <= c) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) return 0;
    lo = lo - 1;
    if (lo > n - 2) lo = n - 2;
    return lo;
  endfunction

  function automatic longint part_weight(longint num, longint den);
    longint w;
    if (num <= 0) return 0;
    w = (num * ONE_Q16) / den;
    return (w > ONE_Q16) ? longint'(ONE_Q16) : w;
  endfunction

  function automatic void corner_weights(longint a, longint b, longint c,
                                         output longint w_lo, output longint w_hi);
    longint d;
    d = b - a;
    if (d <= 0) begin
      w_lo = ONE_Q16;
      w_hi = 0;
    end else begin
      w_lo = part_weight(b - c, d);
      w_hi = part_weight(c - a, d);
    end
  endfunction

  function automatic out_beat_t blend_point(longint px, longint py);
    out_beat_t   r;
    int unsigned nx;
    int unsigned ny;
    int unsigned ci;
    int unsigned cj;
    int unsigned base;
    longint      wxl, wxh, wyl, wyh, q11, q12, q21, q22, r1, r2, v;
    nx = eff_count(x_count_q, NX_MAX);
    ny = eff_count(y_count_q, NY_MAX);
    r = '0;
    if (px < x_knot_mem[0] || px > x_knot_mem[nx-1] ||
        py < y_knot_mem[0] || py > y_knot_mem[ny-1]) return r;
    ci = cell_index(1'b0, nx, px);
    cj = cell_index(1'b1, ny, py);
    corner_weights(x_knot_mem[ci], x_knot_mem[ci+1], px, wxl, wxh);
    corner_weights(y_knot_mem[cj], y_knot_mem[cj+1], py, wyl, wyh);
    base = ci * ny + cj;
    q11 = grid_mem[base % GRID_N];
    q12 = grid_mem[(base + 1) % GRID_N];
    q21 = grid_mem[(base + ny) % GRID_N];
    q22 = grid_mem[(base + ny + 1) % GRID_N];
    r1 = (wxl * q11 + wxh * q21) >>> FRAC_W;
    r2 = (wxl * q12 + wxh * q22) >>> FRAC_W;
    v  = (wyl * r1 + wyh * r2) >>> FRAC_W;
    if (v > 64'sh7fffffff) v = 64'sh7fffffff;
    if (v < -64'sh80000000) v = -64'sh80000000;
    r.interp_value = v[VALUE_W-1:0];
    r.in_range     = 1'b1;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      result_q.delete();
      x_count_q <= 7'd64;
      y_count_q <= 7'd64;
      err_cnt   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          if (err_cnt < 10)
            $display("unexpected result beat: value %h in_range %b",
                     out_data_i.interp_value, out_data_i.in_range);
          err_cnt <= err_cnt + 1;
        end else begin
          want = result_q.pop_front();
          if (want.interp_value !== out_data_i.interp_value ||
              want.in_range !== out_data_i.in_range) begin
            if (err_cnt < 10)
              $display("result mismatch: expected %h/%b got %h/%b",
                       want.interp_value, want.in_range,
                       out_data_i.interp_value, out_data_i.in_range);
            err_cnt <= err_cnt + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.func)
          FUNC_LOAD_X:
            if (in_data_i.entry_index < NX_MAX)
              x_knot_mem[in_data_i.entry_index[5:0]] = in_data_i.entry_value;
          FUNC_LOAD_Y:
            if (in_data_i.entry_index < NY_MAX)
              y_knot_mem[in_data_i.entry_index[5:0]] = in_data_i.entry_value;
          FUNC_LOAD_G:
            grid_mem[in_data_i.entry_index] = in_data_i.entry_value;
          default:
            result_q.push_back(blend_point(in_data_i.point_x, in_data_i.point_y));
        endcase
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_X_COUNT) x_count_q <= cfg_data_i;
        else if (cfg_index_i == REG_Y_COUNT) y_count_q <= cfg_data_i;
      end
    end
  end

endmodule

@@ tb/tb_grid_bilinear_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// tb_grid_bilinear_interpolator_core
// drives knot, grid and query beats through the interpolator under a range
// of knot counts, with random idling on both channels and one long result
// hold-off; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_grid_bilinear_interpolator_core;
  import gbi_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_beat_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_beat_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COUNT_W-1:0]   cfg_data;
  int                   errors;
  int                   pending;

  logic signed [31:0]   xk [64];
  logic signed [31:0]   yk [64];
  int unsigned          nx;
  int unsigned          ny;
  int                   sent;
  bit                   quiet;
  bit                   hold_req;

  grid_bilinear_interpolator_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  gbi_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("tb_grid_bilinear_interpolator_core: done, errors");
    $finish;
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_beat(in_beat_t b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic load_entry(logic [1:0] f, int unsigned idx, logic [31:0] v);
    in_beat_t b;
    b.func        = f;
    b.entry_index = idx[INDEX_W-1:0];
    b.entry_value = v;
    b.point_x     = $urandom;
    b.point_y     = $urandom;
    send_beat(b);
  endtask

  task automatic query_point(logic [31:0] px, logic [31:0] py);
    in_beat_t b;
    b.func        = FUNC_QUERY;
    b.entry_index = $urandom;
    b.entry_value = $urandom;
    b.point_x     = px;
    b.point_y     = py;
    send_beat(b);
  endtask

  task automatic drain();
    int t;
    t = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && t < 200000) begin
      @(posedge clk);
      t++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int unsigned clamp_cnt(int unsigned c);
    if (c < 2) return 2;
    if (c > 64) return 64;
    return c;
  endfunction

  task automatic set_counts(int unsigned cx, int unsigned cy);
    drain();
    reg_write(REG_X_COUNT, cx[COUNT_W-1:0]);
    reg_write(REG_Y_COUNT, cy[COUNT_W-1:0]);
    nx = clamp_cnt(cx);
    ny = clamp_cnt(cy);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  // mode 0 ascending, 1 ascending with repeats, 2 unordered
  task automatic make_knots(int mode, output logic signed [31:0] k [64]);
    longint v;
    longint step_max;
    step_max = ($urandom_range(0, 1) == 0) ? 64'd131072 : 64'd16777216;
    v = longint'($signed($urandom_range(0, 32'h3fffffff))) - 64'sh20000000;
    for (int i = 0; i < 64; i++) begin
      if (mode == 2) k[i] = $urandom;
      else k[i] = v[31:0];
      if (mode == 1 && $urandom_range(0, 2) == 0) v = v;
      else v = v + 1 + ({$urandom, $urandom} % step_max);
    end
  endtask

  function automatic logic [31:0] pick_coord(logic signed [31:0] k [64], int unsigned n);
    longint lo;
    longint hi;
    lo = k[0];
    hi = k[n-1];
    case ($urandom_range(0, 9))
      0: return k[$urandom_range(0, n-1)];
      1: return k[n-1];
      2: return (lo > -64'sh80000000) ? 32'(lo - 1) : 32'(lo);
      3: return (hi < 64'sh7fffffff) ? 32'(hi + 1) : 32'(hi);
      4: return $urandom;
      default:
        if (hi >= lo) return 32'(lo + longint'({$urandom, $urandom} % (hi - lo + 1)));
        else return $urandom;
    endcase
  endfunction

  task automatic run_phase(int mode, int nq);
    int unsigned g;
    make_knots(mode, xk);
    make_knots(mode, yk);
    for (int i = 0; i < nx; i++) load_entry(FUNC_LOAD_X, i, xk[i]);
    for (int i = 0; i < ny; i++) load_entry(FUNC_LOAD_Y, i, yk[i]);
    g = nx * ny;
    for (int i = 0; i < g; i++) load_entry(FUNC_LOAD_G, i, rand_value());
    for (int q = 0; q < nq; q++) begin
      case ($urandom_range(0, 11))
        0: load_entry(FUNC_LOAD_X, $urandom_range(64, 4095), $urandom);
        1: load_entry(FUNC_LOAD_Y, $urandom_range(64, 4095), $urandom);
        2: load_entry(FUNC_LOAD_G, $urandom_range(0, g-1), rand_value());
        default: query_point(pick_coord(xk, nx), pick_coord(yk, ny));
      endcase
    end
  endtask

  initial begin
    int unsigned cx;
    int unsigned cy;
    int          phase;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    sent      = 0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full-span x, extreme corners, edges and outside points
    set_counts(2, 2);
    reg_write(8'd2, 7'd5);
    load_entry(FUNC_LOAD_X, 0, 32'h80000000);
    load_entry(FUNC_LOAD_X, 1, 32'h7fffffff);
    load_entry(FUNC_LOAD_Y, 0, 32'h00000000);
    load_entry(FUNC_LOAD_Y, 1, 32'h00010000);
    load_entry(FUNC_LOAD_G, 0, 32'h7fffffff);
    load_entry(FUNC_LOAD_G, 1, 32'h80000000);
    load_entry(FUNC_LOAD_G, 2, 32'h7fffffff);
    load_entry(FUNC_LOAD_G, 3, 32'h7fffffff);
    load_entry(FUNC_LOAD_G, 4095, 32'hffffffff);
    load_entry(FUNC_LOAD_X, 4095, 32'h12345678);
    query_point(32'h80000000, 32'h00000000);
    query_point(32'h7fffffff, 32'h00010000);
    query_point(32'h00000000, 32'h00008000);
    query_point(32'h7fffffff, 32'h00000000);
    query_point(32'h00000000, 32'hffffffff);
    query_point(32'h00000000, 32'h00010001);
    // empty and reversed cells, counts below the floor
    set_counts(0, 1);
    load_entry(FUNC_LOAD_X, 0, 32'h00050000);
    load_entry(FUNC_LOAD_X, 1, 32'h00050000);
    load_entry(FUNC_LOAD_Y, 0, 32'h00030000);
    load_entry(FUNC_LOAD_Y, 1, 32'hfff00000);
    query_point(32'h00050000, 32'h00030000);
    query_point(32'h00050000, 32'h00000000);
    query_point(32'h00040000, 32'h00030000);

    phase = 0;
    while (sent < 1850) begin
      case ($urandom_range(0, 9))
        0: begin cx = 64; cy = 2; end
        1: begin cx = 2; cy = 64; end
        2: begin cx = 127; cy = $urandom_range(0, 3); end
        3: begin cx = 0; cy = 1; end
        default: begin cx = $urandom_range(2, 8); cy = $urandom_range(2, 8); end
      endcase
      if (sent > 1550) quiet = 1'b1;
      set_counts(cx, cy);
      if (phase == 3) hold_req = 1'b1;
      run_phase(($urandom_range(0, 5) == 0) ? 2 : $urandom_range(0, 1), 40);
      phase++;
    end

    drain();
    if (errors == 0 && pending == 0)
      $display("tb_grid_bilinear_interpolator_core: done, clean");
    else
      $display("tb_grid_bilinear_interpolator_core: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
hdl/gbi_pkg.sv
hdl/gbi_ram.sv
hdl/grid_bilinear_interpolator_core.sv
tb/gbi_checker.sv
tb/tb_grid_bilinear_interpolator_core.sv
